[src/hgpc_pkg.sv]
// Shared types and constants for the hexagonal grid point-to-cell picker.
// Used by every module in src; depends on nothing else.
package hgpc_pkg;

  localparam int POS_W  = 24;                 // point and edge width, Q15.8
  localparam int STEP_W = 23;                 // step and shift width
  localparam int RAD_W  = 47;                 // squared radius width, Q31.16
  localparam int VIEW_W = 16;                 // view direction width, Q1.14
  localparam int IDX_W  = 16;                 // output column and row width
  localparam int NUM_W  = POS_W + 1;          // signed numerator of the rough divide
  localparam int REM_W  = STEP_W + 1;         // signed remainder
  localparam int DIV_LAT = NUM_W + 2;         // divider latency
  localparam int OFS_W  = 27;                 // centre offset before the far test
  localparam int NEAR_W = 25;                 // offset once known to be near
  localparam int SQ_W   = 2 * (NEAR_W - 1);   // one squared component
  localparam int PROD_W = NEAR_W + VIEW_W;    // one dot product term
  localparam int DOT_W  = PROD_W + 1;
  localparam int CNT_W  = 3;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_EDGE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_EDGE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_STEP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_STEP      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ODD_ROW_SHIFT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_RADIUS = 3'd5;

  localparam logic [STEP_W-1:0] COLUMN_STEP_RESET   = 23'd14190;
  localparam logic [STEP_W-1:0] ROW_STEP_RESET      = 23'd12288;
  localparam logic [STEP_W-1:0] ODD_ROW_SHIFT_RESET = 23'd7094;
  localparam logic [RAD_W-1:0]  SEARCH_RADIUS_RESET = 47'd84934656;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NONE     = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  typedef struct packed {
    logic signed [POS_W-1:0]  point_x;
    logic signed [POS_W-1:0]  point_y;
    logic signed [VIEW_W-1:0] view_x;
    logic signed [VIEW_W-1:0] view_y;
  } query_t;

  typedef struct packed {
    logic signed [IDX_W-1:0] cell_column;
    logic signed [IDX_W-1:0] cell_row;
    logic [1:0]              pick_status;
  } result_t;

  typedef struct packed {
    logic [STEP_W-1:0] column_step;
    logic [STEP_W-1:0] row_step;
    logic [STEP_W-1:0] odd_row_shift;
    logic [RAD_W-1:0]  search_radius_squared;
  } grid_cfg_t;

  // Per-item state handed along the row of cells.
  typedef struct packed {
    logic                     valid;
    logic signed [REM_W-1:0]  rem_x;
    logic signed [REM_W-1:0]  rem_y;
    logic [IDX_W-1:0]         rough_col;
    logic [IDX_W-1:0]         rough_row;
    logic signed [VIEW_W-1:0] view_x;
    logic signed [VIEW_W-1:0] view_y;
    logic [CNT_W-1:0]         count;
    logic                     overflow;
    logic signed [DOT_W-1:0]  best_dot;
    logic [IDX_W-1:0]         best_col;
    logic [IDX_W-1:0]         best_row;
  } cell_state_t;

endpackage

[src/hgpc_div.sv]
// Pipelined signed divider, one quotient bit per stage, truncating toward zero.
// Uses hgpc_pkg for widths; gives the low quotient bits and the signed remainder.
module hgpc_div (
  input  logic                               clk,
  input  logic signed [hgpc_pkg::NUM_W-1:0]  num,
  input  logic [hgpc_pkg::STEP_W-1:0]        den,
  output logic [hgpc_pkg::IDX_W-1:0]         quot,
  output logic signed [hgpc_pkg::REM_W-1:0]  rem
);

  localparam int NW = hgpc_pkg::NUM_W;
  localparam int DW = hgpc_pkg::STEP_W;

  logic [DW-1:0] p_rem [0:NW];
  logic [NW-1:0] p_num [0:NW];
  logic [DW-1:0] p_den [0:NW];
  logic          p_neg [0:NW];
  logic [NW-1:0] mag;

  assign mag = num[NW-1] ? NW'(-num) : NW'(num);

  always_ff @(posedge clk) begin
    p_rem[0] <= '0;
    p_num[0] <= mag;
    p_den[0] <= den;
    p_neg[0] <= num[NW-1];
  end

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic [DW:0] trial;
    logic        take;
    assign trial = {p_rem[i], p_num[i][NW-1]};
    assign take  = trial >= {1'b0, p_den[i]};
    always_ff @(posedge clk) begin
      p_rem[i+1] <= take ? DW'(trial - {1'b0, p_den[i]}) : DW'(trial);
      p_num[i+1] <= {p_num[i][NW-2:0], take};
      p_den[i+1] <= p_den[i];
      p_neg[i+1] <= p_neg[i];
    end
  end

  // Quotient and remainder take the sign of the numerator.
  always_ff @(posedge clk) begin
    quot <= p_neg[NW] ? hgpc_pkg::IDX_W'(-p_num[NW]) : hgpc_pkg::IDX_W'(p_num[NW]);
    rem  <= p_neg[NW] ? -$signed({1'b0, p_rem[NW]}) : $signed({1'b0, p_rem[NW]});
  end

endmodule

[src/hgpc_cell.sv]
// One neighbourhood cell of the scan: tests one candidate centre and updates the pick.
// Uses hgpc_pkg types; three register stages from state in to state out.
module hgpc_cell #(
  parameter int DC = 0,
  parameter int DR = 0,
  parameter int MAX_CANDIDATES = 3
) (
  input  logic                    clk,
  input  logic                    rst,
  input  hgpc_pkg::grid_cfg_t     cfg,
  input  hgpc_pkg::cell_state_t   st_in,
  output hgpc_pkg::cell_state_t   st_out
);

  localparam int OW = hgpc_pkg::OFS_W;
  localparam int NW = hgpc_pkg::NEAR_W;
  localparam logic DR_ODD = (DR % 2) != 0;

  hgpc_pkg::cell_state_t a_st, b_st, st_next;
  logic signed [NW-1:0] a_dx, a_dy;
  logic                 a_near, b_near;
  logic [hgpc_pkg::SQ_W-1:0]          b_xx, b_yy;
  logic signed [hgpc_pkg::PROD_W-1:0] b_dot_x, b_dot_y;

  logic signed [OW-1:0] dc_ofs, dr_ofs, dx, dy, shift;
  logic                 near_x, near_y;
  logic signed [2*NW-1:0] sq_x, sq_y;
  logic [hgpc_pkg::SQ_W:0] dist_sq;
  logic signed [hgpc_pkg::DOT_W-1:0] dot;
  logic                 hit;

  // Centre minus point is the divide remainder moved by whole steps.
  assign dc_ofs = $signed(OW'(DC)) * $signed({{(OW-hgpc_pkg::STEP_W){1'b0}}, cfg.column_step});
  assign dr_ofs = $signed(OW'(DR)) * $signed({{(OW-hgpc_pkg::STEP_W){1'b0}}, cfg.row_step});
  assign shift  = (st_in.rough_row[0] ^ DR_ODD)
                ? $signed({{(OW-hgpc_pkg::STEP_W){1'b0}}, cfg.odd_row_shift}) : '0;
  assign dx = dc_ofs + shift - OW'(st_in.rem_x);
  assign dy = OW'(st_in.rem_y) - dr_ofs;

  // Near means the magnitude is below two to the 24.
  assign near_x = (dx[OW-1:NW-1] == '0) ||
                  ((dx[OW-1:NW-1] == '1) && (dx[NW-2:0] != '0));
  assign near_y = (dy[OW-1:NW-1] == '0) ||
                  ((dy[OW-1:NW-1] == '1) && (dy[NW-2:0] != '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      a_st.valid <= 1'b0;
    end else begin
      a_st <= st_in;
    end
    a_dx   <= dx[NW-1:0];
    a_dy   <= dy[NW-1:0];
    a_near <= near_x && near_y;
  end

  assign sq_x = a_dx * a_dx;
  assign sq_y = a_dy * a_dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_st.valid <= 1'b0;
    end else begin
      b_st <= a_st;
    end
    b_near  <= a_near;
    b_xx    <= sq_x[hgpc_pkg::SQ_W-1:0];
    b_yy    <= sq_y[hgpc_pkg::SQ_W-1:0];
    b_dot_x <= hgpc_pkg::PROD_W'(a_dx) * hgpc_pkg::PROD_W'(a_st.view_x);
    b_dot_y <= hgpc_pkg::PROD_W'(a_dy) * hgpc_pkg::PROD_W'(a_st.view_y);
  end

  assign dist_sq = {1'b0, b_xx} + {1'b0, b_yy};
  assign dot  = hgpc_pkg::DOT_W'(b_dot_x) + hgpc_pkg::DOT_W'(b_dot_y);
  assign hit  = b_near && (dist_sq < {{(hgpc_pkg::SQ_W+1-hgpc_pkg::RAD_W){1'b0}},
                                      cfg.search_radius_squared});

  always_comb begin
    st_next = b_st;
    if (hit) begin
      if (b_st.count >= hgpc_pkg::CNT_W'(MAX_CANDIDATES)) begin
        st_next.overflow = 1'b1;
      end else begin
        st_next.count = b_st.count + 1'b1;
        // A tie keeps the earlier candidate.
        if ((b_st.count == '0) || (dot > b_st.best_dot)) begin
          st_next.best_dot = dot;
          st_next.best_col = b_st.rough_col + hgpc_pkg::IDX_W'(DC);
          st_next.best_row = b_st.rough_row + hgpc_pkg::IDX_W'(DR);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_out.valid <= 1'b0;
    end else begin
      st_out <= st_next;
    end
  end

endmodule

[src/hex_grid_point_to_cell_top.sv]
// Top level of the hexagonal grid point-to-cell picker.
// Depends on hgpc_pkg, hgpc_div and hgpc_cell.
//
// Usage:
//   An item (point and view direction) is taken on a clock edge with start high
//   and busy low. Busy is never raised, so one item may enter every cycle.
//   Each item yields one result, shown on result for exactly one cycle with
//   done high. The receiver cannot stall; results are never held.
//   Pipeline: the two rough divides run in a bit-per-stage divider, then
//   each of the (2*SEARCH_SPAN+1)^2 cells of the scan works in registered
//   steps (offset, multiply, compare and select), then one output
//   register holds the result.
//   Throughput is one item per cycle, set by the fully pipelined divider and
//   the row of cells.
//   The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
//   always ready; registers should be written only while no item is in flight.
//   Reset (rst, synchronous) restores the register defaults and drops every
//   item in flight; no result comes out for an item that was cut off.
module hex_grid_point_to_cell_top #(
  parameter int SEARCH_SPAN    = 2,
  parameter int MAX_CANDIDATES = 3
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  hgpc_pkg::query_t                     query,
  output logic                                 done,
  output hgpc_pkg::result_t                    result,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [hgpc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hgpc_pkg::RAD_W-1:0]           cfg_data
);

  localparam int SIDE   = 2 * SEARCH_SPAN + 1;
  localparam int CELLS  = SIDE * SIDE;
  localparam int NW     = hgpc_pkg::NUM_W;
  localparam int LAT    = hgpc_pkg::DIV_LAT;

  logic signed [hgpc_pkg::POS_W-1:0] left_edge;
  logic [hgpc_pkg::STEP_W-1:0]       top_edge;
  hgpc_pkg::grid_cfg_t               cfg;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_edge                 <= '0;
      top_edge                  <= '0;
      cfg.column_step           <= hgpc_pkg::COLUMN_STEP_RESET;
      cfg.row_step              <= hgpc_pkg::ROW_STEP_RESET;
      cfg.odd_row_shift         <= hgpc_pkg::ODD_ROW_SHIFT_RESET;
      cfg.search_radius_squared <= hgpc_pkg::SEARCH_RADIUS_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        hgpc_pkg::REG_LEFT_EDGE:     left_edge <= cfg_data[hgpc_pkg::POS_W-1:0];
        hgpc_pkg::REG_TOP_EDGE:      top_edge <= cfg_data[hgpc_pkg::STEP_W-1:0];
        hgpc_pkg::REG_COLUMN_STEP:   cfg.column_step <= cfg_data[hgpc_pkg::STEP_W-1:0];
        hgpc_pkg::REG_ROW_STEP:      cfg.row_step <= cfg_data[hgpc_pkg::STEP_W-1:0];
        hgpc_pkg::REG_ODD_ROW_SHIFT: cfg.odd_row_shift <= cfg_data[hgpc_pkg::STEP_W-1:0];
        hgpc_pkg::REG_SEARCH_RADIUS: cfg.search_radius_squared <= cfg_data;
        default: ;
      endcase
    end
  end

  logic signed [NW-1:0]        num_x, num_y;
  logic [hgpc_pkg::STEP_W-1:0] den_x, den_y;
  logic [hgpc_pkg::IDX_W-1:0]  quot_x, quot_y;
  logic signed [hgpc_pkg::REM_W-1:0] rem_x, rem_y;

  assign num_x = NW'(query.point_x) - NW'(left_edge);
  assign num_y = $signed({2'b00, top_edge}) - NW'(query.point_y);
  // A zero step is taken as one.
  assign den_x = (cfg.column_step == '0) ? hgpc_pkg::STEP_W'(1) : cfg.column_step;
  assign den_y = (cfg.row_step == '0) ? hgpc_pkg::STEP_W'(1) : cfg.row_step;

  hgpc_div u_div_x (.clk(clk), .num(num_x), .den(den_x), .quot(quot_x), .rem(rem_x));
  hgpc_div u_div_y (.clk(clk), .num(num_y), .den(den_y), .quot(quot_y), .rem(rem_y));

  // The view direction and valid flag travel beside the divider.
  logic                            side_valid [0:LAT-1];
  logic signed [hgpc_pkg::VIEW_W-1:0] side_vx [0:LAT-1];
  logic signed [hgpc_pkg::VIEW_W-1:0] side_vy [0:LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) begin
        side_valid[i] <= 1'b0;
      end
    end else begin
      side_valid[0] <= start && !busy;
      for (int i = 1; i < LAT; i++) begin
        side_valid[i] <= side_valid[i-1];
      end
    end
    side_vx[0] <= query.view_x;
    side_vy[0] <= query.view_y;
    for (int i = 1; i < LAT; i++) begin
      side_vx[i] <= side_vx[i-1];
      side_vy[i] <= side_vy[i-1];
    end
  end

  hgpc_pkg::cell_state_t chain [0:CELLS];

  always_comb begin
    chain[0]           = '0;
    chain[0].valid     = side_valid[LAT-1];
    chain[0].rem_x     = rem_x;
    chain[0].rem_y     = rem_y;
    chain[0].rough_col = quot_x;
    chain[0].rough_row = quot_y;
    chain[0].view_x    = side_vx[LAT-1];
    chain[0].view_y    = side_vy[LAT-1];
  end

  // Column outer, row inner, matching the scan order of the pick.
  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    hgpc_cell #(
      .DC(k / SIDE - SEARCH_SPAN),
      .DR(k % SIDE - SEARCH_SPAN),
      .MAX_CANDIDATES(MAX_CANDIDATES)
    ) u_cell (
      .clk(clk),
      .rst(rst),
      .cfg(cfg),
      .st_in(chain[k]),
      .st_out(chain[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= chain[CELLS].valid;
    end
    if (chain[CELLS].count == '0) begin
      result.cell_column <= '0;
      result.cell_row    <= '0;
      result.pick_status <= hgpc_pkg::STATUS_NONE;
    end else begin
      result.cell_column <= chain[CELLS].best_col;
      result.cell_row    <= chain[CELLS].best_row;
      result.pick_status <= chain[CELLS].overflow ? hgpc_pkg::STATUS_OVERFLOW
                                                  : hgpc_pkg::STATUS_OK;
    end
  end

endmodule

[dv/tb.sv]
// Testbench for the hexagonal grid point-to-cell picker.
// Depends on hgpc_pkg and hex_grid_point_to_cell_top; checks every result
// against an in-bench prediction of the picked cell and its status.
`timescale 1ns / 1ps

module tb;

  localparam int LATENCY = 103;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  hgpc_pkg::query_t query;
  logic done;
  hgpc_pkg::result_t result;
  logic cfg_valid;
  logic cfg_ready;
  logic [hgpc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [hgpc_pkg::RAD_W-1:0] cfg_data;

  hex_grid_point_to_cell_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .query(query),
    .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Grid settings as the bench believes them to be.
  longint g_left, g_top, g_cstep, g_rstep, g_shift, g_radius;

  hgpc_pkg::query_t pending_queries[$];
  hgpc_pkg::result_t expected_cells[$];
  int mismatches;
  int gap;
  bit feeding_done;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic hgpc_pkg::result_t pick_cell(hgpc_pkg::query_t q);
    longint px, py, vx, vy, cs, rs, rc, rr, c, r, cx, cy, dx, dy, dot, best_dot;
    longint adx, ady;
    int count;
    bit over;
    hgpc_pkg::result_t res;
    px = longint'(q.point_x);
    py = longint'(q.point_y);
    vx = longint'(q.view_x);
    vy = longint'(q.view_y);
    cs = (g_cstep != 0) ? g_cstep : 1;
    rs = (g_rstep != 0) ? g_rstep : 1;
    rc = (px - g_left) / cs;
    rr = (g_top - py) / rs;
    count = 0;
    over = 1'b0;
    best_dot = 0;
    res = '0;
    for (int dc = -2; dc <= 2; dc++) begin
      for (int dr = -2; dr <= 2; dr++) begin
        c = rc + dc;
        r = rr + dr;
        cx = g_left + c * cs + (r[0] ? g_shift : 0);
        cy = g_top - r * rs;
        dx = cx - px;
        dy = cy - py;
        adx = dx < 0 ? -dx : dx;
        ady = dy < 0 ? -dy : dy;
        if (adx >= (64'sd1 << 24) || ady >= (64'sd1 << 24)) continue;
        if (dx * dx + dy * dy >= g_radius) continue;
        if (count >= 3) begin
          over = 1'b1;
          continue;
        end
        dot = dx * vx + dy * vy;
        // Strictly greater keeps the earlier candidate on a tie.
        if (count == 0 || dot > best_dot) begin
          best_dot = dot;
          res.cell_column = c[15:0];
          res.cell_row = r[15:0];
        end
        count++;
      end
    end
    if (count == 0) begin
      res = '0;
      res.pick_status = hgpc_pkg::STATUS_NONE;
    end else begin
      res.pick_status = over ? hgpc_pkg::STATUS_OVERFLOW : hgpc_pkg::STATUS_OK;
    end
    return res;
  endfunction

  // Driver: one item from the queue per accepted start, with random gaps.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap <= 0;
    end else if (start && !busy) begin
      expected_cells.push_back(pick_cell(query));
      if (pending_queries.size() > 0 && gap == 0) begin
        query <= pending_queries.pop_front();
        gap <= (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13));
      end else begin
        start <= 1'b0;
      end
    end else if (!start) begin
      if (gap > 0) begin
        gap <= gap - 1;
      end else if (pending_queries.size() > 0) begin
        query <= pending_queries.pop_front();
        start <= 1'b1;
        gap <= (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13));
      end
    end
  end

  // Monitor.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_cells.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", result);
      end else begin
        hgpc_pkg::result_t want;
        want = expected_cells.pop_front();
        if (result.cell_column !== want.cell_column || result.cell_row !== want.cell_row ||
            result.pick_status !== want.pick_status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %0d %0d st %0d, got %0d %0d st %0d",
                     want.cell_column, want.cell_row, want.pick_status,
                     result.cell_column, result.cell_row, result.pick_status);
        end
      end
    end
  end

  task automatic write_reg(logic [hgpc_pkg::CFG_IDX_W-1:0] idx, longint value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[hgpc_pkg::RAD_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      hgpc_pkg::REG_LEFT_EDGE: g_left = longint'(signed'(value[23:0]));
      hgpc_pkg::REG_TOP_EDGE: g_top = value & 64'h7F_FFFF;
      hgpc_pkg::REG_COLUMN_STEP: g_cstep = value & 64'h7F_FFFF;
      hgpc_pkg::REG_ROW_STEP: g_rstep = value & 64'h7F_FFFF;
      hgpc_pkg::REG_ODD_ROW_SHIFT: g_shift = value & 64'h7F_FFFF;
      hgpc_pkg::REG_SEARCH_RADIUS: g_radius = value & 64'h7FFF_FFFF_FFFF;
      default: ;
    endcase
  endtask

  task automatic write_grid(longint le, longint te, longint cs, longint rs, longint sh,
                            longint rad);
    write_reg(hgpc_pkg::REG_LEFT_EDGE, le);
    write_reg(hgpc_pkg::REG_TOP_EDGE, te);
    write_reg(hgpc_pkg::REG_COLUMN_STEP, cs);
    write_reg(hgpc_pkg::REG_ROW_STEP, rs);
    write_reg(hgpc_pkg::REG_ODD_ROW_SHIFT, sh);
    write_reg(hgpc_pkg::REG_SEARCH_RADIUS, rad);
  endtask

  task automatic add_query(int px, int py, int vx, int vy);
    hgpc_pkg::query_t q;
    q.point_x = px[23:0];
    q.point_y = py[23:0];
    q.view_x = vx[15:0];
    q.view_y = vy[15:0];
    pending_queries.push_back(q);
  endtask

  // Points mostly near the grid, sometimes anywhere in the field's range.
  task automatic add_random(int n, int span);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0)
        add_query($urandom, $urandom, $urandom, $urandom);
      else
        add_query(int'(g_left) + $urandom_range(0, span) - span / 8,
                  int'(g_top) - $urandom_range(0, span) + span / 8,
                  $urandom, $urandom);
    end
  endtask

  task automatic drain;
    while (pending_queries.size() > 0 || start || expected_cells.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    query = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatches = 0;
    g_left = 0;
    g_top = 0;
    g_cstep = hgpc_pkg::COLUMN_STEP_RESET;
    g_rstep = hgpc_pkg::ROW_STEP_RESET;
    g_shift = hgpc_pkg::ODD_ROW_SHIFT_RESET;
    g_radius = hgpc_pkg::SEARCH_RADIUS_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed items at the reset grid: extremes, ties and no candidate.
    add_query(0, 0, 0, 0);
    add_query(0, 0, 16384, 0);
    add_query(0, 0, -32768, -32768);
    add_query(0, 0, 32767, 32767);
    add_query(8388607, 8388607, 32767, -32768);
    add_query(-8388608, -8388608, -32768, 32767);
    add_query(-8388608, 8388607, 0, 16384);
    add_query(8388607, -8388608, 0, -16384);
    add_query(7095, -6144, 100, 100);
    add_query(-14190, 12288, -5, 7);
    add_query(100000, -200000, 1, -1);
    add_query(-1, -1, 32767, 0);
    add_random(120, 200000);
    drain();

    // Zero steps, tiny radius: never a candidate.
    write_grid(-8388608, 8388607, 0, 0, 8388607, 0);
    add_query(-8388608, 8388607, 1, 1);
    add_random(100, 64);
    drain();

    // Huge radius and small steps: many candidates, overflow status.
    write_grid(-1000, 3000, 5, 7, 2, 64'h7FFF_FFFF_FFFF);
    add_random(150, 200);
    drain();

    write_grid(0, 0, 8388607, 8388607, 0, 64'd1 << 40);
    add_random(100, 8388607);
    drain();

    // Varied grids with random content.
    for (int k = 0; k < 8; k++) begin
      write_grid(-$urandom_range(0, 8388608), $urandom_range(0, 8388607),
                 $urandom_range(1, 40000), $urandom_range(1, 40000),
                 $urandom_range(0, 20000),
                 {$urandom_range(0, 15), $urandom});
      add_random(110, 300000);
      drain();
    end

    write_grid(0, 0, 14190, 12288, 7094, 84934656);
    add_random(100, 300000);
    drain();

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[filelist.f]
src/hgpc_pkg.sv
src/hgpc_div.sv
src/hgpc_cell.sv
src/hex_grid_point_to_cell_top.sv
dv/tb.sv
